// ===== rtl/cdi_pkg.sv =====
// shared widths, codes and types of the curve difference interpolator
`default_nettype none
package cdi_pkg;

	localparam int XW        = 32;
	localparam int QW        = XW + 1;
	localparam int PW        = XW + QW;
	localparam int CNT_W     = 6;
	localparam int MUL_STEPS = XW;
	localparam int DIV_STEPS = QW;
	localparam int RW        = XW + 4;

	localparam logic FUNC_REF    = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;
	localparam logic WANT_REF    = 1'b0;
	localparam logic WANT_SAMPLE = 1'b1;

	typedef struct packed {
		logic busy;
		logic done;
	} cdi_md_stat_t;

endpackage
`default_nettype wire

// ===== rtl/curve_difference_interpolator_top.sv =====
// curve difference interpolator: segment tracking, sample hold and result output
//
// channel  dir  tdata (low bit up)              tuser (low bit up)
// s_axis   in   point_x[31:0], point_y[63:32]   func[0]
// m_axis   out  out_x[31:0], difference[63:32] diff_valid[0], want_next[1]
//
// a reference point, a dropped or held sample goes from ST_IDLE straight to ST_DONE
// an evaluated sample passes ST_SETUP and ST_PREP, the bit-serial multiply (32 steps)
// and the restoring divide (33 steps) in ST_CALC, then ST_FIN into the result register
// one item in work at a time; the next is taken while a result waits on m_axis
// a stalled m_tready holds a finished result in ST_DONE and blocks further input
// arst_n clears the segment, the held sample and all handshake state
`default_nettype none
module curve_difference_interpolator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // point_x, point_y
	input  wire logic [0:0]  s_tuser,  // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,  // out_x, difference
	output logic      [1:0]  m_tuser   // diff_valid, want_next
);
	import cdi_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SETUP = 6'b000010,
		ST_PREP  = 6'b000100,
		ST_CALC  = 6'b001000,
		ST_FIN   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t               state_q;
	logic [XW-1:0]        left_x_q, left_y_q, right_x_q, right_y_q;
	logic [1:0]           ref_seen_q;
	logic [XW-1:0]        held_x_q, held_y_q;
	logic                 held_valid_q;
	logic [XW-1:0]        eval_x_q, eval_y_q;
	logic [XW-1:0]        a_q, d_q;
	logic [QW-1:0]        dy_q, b_q;
	logic                 neg_q;
	logic                 res_valid_q, res_want_q;
	logic [XW-1:0]        res_x_q, res_diff_q;
	logic                 out_valid_q;
	logic [63:0]          out_data_q;
	logic [1:0]           out_user_q;

	logic                 accept;
	logic                 in_func;
	logic [XW-1:0]        px, py;
	logic                 do_eval, held_valid_nxt, load_held, take_held;
	logic                 seg_move, first_ref;
	logic [QW-1:0]        md_q;
	cdi_md_stat_t         md_stat;
	logic [RW-1:0]        interp, r_full;
	logic [XW-1:0]        r_sat;
	logic                 out_free;
	logic                 out_load;

	assign in_func  = s_tuser[0];
	assign px       = s_tdata[31:0];
	assign py       = s_tdata[63:32];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_DONE) && out_free;

	// what an accepted item does to the segment and the held sample
	always_comb begin
		do_eval        = 1'b0;
		held_valid_nxt = held_valid_q;
		load_held      = 1'b0;
		take_held      = 1'b0;
		seg_move       = 1'b0;
		first_ref      = 1'b0;
		if (in_func == FUNC_REF) begin
			if (ref_seen_q == 2'd0) begin
				first_ref = 1'b1;
			end else if ($signed(px) > $signed(right_x_q)) begin
				seg_move = 1'b1;
				if (held_valid_q) begin
					if ($signed(held_x_q) < $signed(right_x_q)) begin
						held_valid_nxt = 1'b0;
					end else if ($signed(held_x_q) < $signed(px)) begin
						held_valid_nxt = 1'b0;
						do_eval        = 1'b1;
						take_held      = 1'b1;
					end
				end
			end
		end else begin
			held_valid_nxt = 1'b0;
			if (ref_seen_q != 2'd2) begin
				held_valid_nxt = 1'b1;
				load_held      = 1'b1;
			end else if ($signed(px) >= $signed(right_x_q)) begin
				held_valid_nxt = 1'b1;
				load_held      = 1'b1;
			end else if ($signed(px) >= $signed(left_x_q)) begin
				do_eval = 1'b1;
			end
		end
	end

	assign interp = neg_q ? ({{(RW-XW){left_y_q[XW-1]}}, left_y_q} - {{(RW-QW){1'b0}}, md_q})
	                      : ({{(RW-XW){left_y_q[XW-1]}}, left_y_q} + {{(RW-QW){1'b0}}, md_q});
	assign r_full = interp - {{(RW-XW){eval_y_q[XW-1]}}, eval_y_q};

	always_comb begin
		if (r_full[RW-1:XW-1] == '0 || r_full[RW-1:XW-1] == '1) begin
			r_sat = r_full[XW-1:0];
		end else if (r_full[RW-1]) begin
			r_sat = {1'b1, {(XW-1){1'b0}}};
		end else begin
			r_sat = {1'b0, {(XW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			left_x_q     <= '0;
			left_y_q     <= '0;
			right_x_q    <= '0;
			right_y_q    <= '0;
			ref_seen_q   <= 2'd0;
			held_x_q     <= '0;
			held_y_q     <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						held_valid_q <= held_valid_nxt;
						if (load_held) begin
							held_x_q <= px;
							held_y_q <= py;
						end
						if (first_ref) begin
							right_x_q  <= px;
							right_y_q  <= py;
							ref_seen_q <= 2'd1;
						end
						if (seg_move) begin
							left_x_q   <= right_x_q;
							left_y_q   <= right_y_q;
							right_x_q  <= px;
							right_y_q  <= py;
							ref_seen_q <= 2'd2;
						end
						state_q <= do_eval ? ST_SETUP : ST_DONE;
					end
				end
				ST_SETUP: state_q <= ST_PREP;
				ST_PREP:  state_q <= ST_CALC;
				ST_CALC: begin
					if (md_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					eval_x_q    <= take_held ? held_x_q : px;
					eval_y_q    <= take_held ? held_y_q : py;
					res_valid_q <= 1'b0;
					res_x_q     <= '0;
					res_diff_q  <= '0;
					res_want_q  <= held_valid_nxt ? WANT_REF : WANT_SAMPLE;
				end
			end
			ST_SETUP: begin
				a_q  <= eval_x_q - left_x_q;
				d_q  <= right_x_q - left_x_q;
				dy_q <= {right_y_q[XW-1], right_y_q} - {left_y_q[XW-1], left_y_q};
			end
			ST_PREP: begin
				neg_q <= dy_q[QW-1];
				b_q   <= dy_q[QW-1] ? (~dy_q + 1'b1) : dy_q;
			end
			ST_FIN: begin
				res_valid_q <= 1'b1;
				res_x_q     <= eval_x_q;
				res_diff_q  <= r_sat;
			end
			ST_DONE: begin
				if (out_free) begin
					out_data_q <= {res_diff_q, res_x_q};
					out_user_q <= {res_want_q, res_valid_q};
				end
			end
			default: begin
				res_valid_q <= res_valid_q;
			end
		endcase
	end

	cdi_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_PREP),
		.a      (a_q),
		.b      (b_q),
		.d      (d_q),
		.q      (md_q),
		.stat   (md_stat)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	a_refseen_range: assert property (@(posedge clk) disable iff (!arst_n)
		ref_seen_q != 2'd3)
		else $error("reference count out of range");

	a_segment_order: assert property (@(posedge clk) disable iff (!arst_n)
		ref_seen_q == 2'd2 |-> $signed(left_x_q) < $signed(right_x_q))
		else $error("segment left end not below right end");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_stat.done |-> state_q == ST_CALC)
		else $error("divider finished outside calculation");

	a_diff_wants_sample: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[1] == WANT_SAMPLE)
		else $error("difference given while a sample is held");

	a_no_diff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("non-zero payload on a result without difference");

endmodule
`default_nettype wire

// ===== rtl/cdi_muldiv.sv =====
// bit-serial multiply then restoring divide: q = a * b / d, truncated
`default_nettype none
module cdi_muldiv (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [cdi_pkg::XW-1:0]    a,
	input  wire logic [cdi_pkg::QW-1:0]    b,
	input  wire logic [cdi_pkg::XW-1:0]    d,
	output logic      [cdi_pkg::QW-1:0]    q,
	output cdi_pkg::cdi_md_stat_t          stat
);
	import cdi_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_MUL  = 3'b010,
		M_DIV  = 3'b100
	} md_state_t;

	md_state_t         state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PW-1:0]     acc_q;
	logic              done_q;
	logic [QW:0]       mul_sum;
	logic [QW-1:0]     div_t;
	logic              div_ge;
	logic [QW-1:0]     div_sub;

	// multiply: add b into the upper part when the low bit of a is set, shift right
	assign mul_sum = {1'b0, acc_q[PW-1:XW]} + (acc_q[0] ? {1'b0, b} : '0);

	// divide: remainder in the upper 32 bits, dividend and quotient share the low part
	assign div_t   = {acc_q[PW-1:QW], acc_q[QW-1]};
	assign div_ge  = div_t >= {1'b0, d};
	assign div_sub = div_t - {1'b0, d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_MUL;
						cnt_q   <= '0;
					end
				end
				M_MUL: begin
					if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
						state_q <= M_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				M_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= M_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (start) begin
					acc_q <= {{QW{1'b0}}, a};
				end
			end
			M_MUL: begin
				acc_q <= {mul_sum, acc_q[XW-1:1]};
			end
			M_DIV: begin
				acc_q <= {(div_ge ? div_sub[XW-1:0] : div_t[XW-1:0]),
					acc_q[QW-2:0], div_ge};
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign q         = acc_q[QW-1:0];
	assign stat.busy = (state_q != M_IDLE);
	assign stat.done = done_q;

endmodule
`default_nettype wire
